@@ rtl/pitch_quantizer_defines.svh @@
// Assertion macros shared by the pitch quantizer checker.
// Every macro samples on clk; the gated form is disabled while rst_n is low.
`ifndef PITCH_QUANTIZER_DEFINES_SVH
`define PITCH_QUANTIZER_DEFINES_SVH
`define PQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`define PQ_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/pq_pkg.sv @@
// Shared types and constants of the pitch quantizer.
// No dependencies; used by every design module of the block.
`default_nettype none
package pq_pkg;
  localparam int LOG_FRAC = 28;
  localparam int DIV_BITS = 50;
  localparam logic [31:0] BASE_RESET = 32'd28835840;
  localparam logic [15:0] STEPS_RESET = 16'd3072;

  typedef enum logic {
    CFG_BASE  = 1'b0,
    CFG_STEPS = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } pq_ctl_t;
endpackage
`default_nettype wire

@@ rtl/pq_log.sv @@
// Two-lane log2 pipeline: normalization, 28 squaring stages, difference.
// Depends on pq_pkg.
`default_nettype none
module pq_log (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  pq_pkg::pq_ctl_t       ctl_i,
  input  logic [31:0]           mag_i,
  input  logic [31:0]           base_i,
  output pq_pkg::pq_ctl_t       ctl_o,
  output logic signed [33:0]    diff_o
);
  import pq_pkg::*;

  function automatic logic [4:0] msb_pos(input logic [31:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) p = 5'(i);
    end
    return p;
  endfunction

  pq_ctl_t               ctl_r  [0:LOG_FRAC];
  logic [31:0]           mf_r   [0:LOG_FRAC];
  logic [31:0]           mb_r   [0:LOG_FRAC];
  logic [LOG_FRAC-1:0]   ff_r   [0:LOG_FRAC];
  logic [LOG_FRAC-1:0]   fb_r   [0:LOG_FRAC];
  logic [4:0]            tf_r   [0:LOG_FRAC];
  logic [4:0]            tb_r   [0:LOG_FRAC];
  logic [4:0]            tf_nxt, tb_nxt;
  pq_ctl_t               ctl_out_r;
  logic signed [33:0]    diff_r;

  assign tf_nxt = msb_pos(mag_i);
  assign tb_nxt = msb_pos(base_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tf_r[0] <= tf_nxt;
      tb_r[0] <= tb_nxt;
      mf_r[0] <= mag_i << (5'd31 - tf_nxt);
      mb_r[0] <= base_i << (5'd31 - tb_nxt);
      ff_r[0] <= '0;
      fb_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
    logic [63:0] sqf, sqb;
    logic [32:0] tf, tb;
    assign sqf = 64'(mf_r[k]) * 64'(mf_r[k]);
    assign sqb = 64'(mb_r[k]) * 64'(mb_r[k]);
    assign tf  = sqf[63:31];
    assign tb  = sqb[63:31];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else if (en) begin
        ctl_r[k+1] <= ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tf_r[k+1] <= tf_r[k];
        tb_r[k+1] <= tb_r[k];
        mf_r[k+1] <= tf[32] ? tf[32:1] : tf[31:0];
        mb_r[k+1] <= tb[32] ? tb[32:1] : tb[31:0];
        ff_r[k+1] <= {ff_r[k][LOG_FRAC-2:0], tf[32]};
        fb_r[k+1] <= {fb_r[k][LOG_FRAC-2:0], tb[32]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_out_r <= '0;
    end else if (en) begin
      ctl_out_r <= ctl_r[LOG_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= $signed({1'b0, tf_r[LOG_FRAC], ff_r[LOG_FRAC]})
              - $signed({1'b0, tb_r[LOG_FRAC], fb_r[LOG_FRAC]});
    end
  end

  assign ctl_o  = ctl_out_r;
  assign diff_o = diff_r;
endmodule
`default_nettype wire

@@ rtl/pq_div.sv @@
// Step index rounding and pipelined restoring divider, one quotient bit per stage.
// Depends on pq_pkg.
`default_nettype none
module pq_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  pq_pkg::pq_ctl_t             ctl_i,
  input  logic signed [33:0]          diff_i,
  input  logic [15:0]                 steps_i,
  output pq_pkg::pq_ctl_t             ctl_o,
  output logic [pq_pkg::DIV_BITS-1:0] q_o,
  output logic                        neg_o
);
  import pq_pkg::*;

  pq_ctl_t              ctl_a_r;
  logic signed [50:0]   a_r;
  logic signed [50:0]   a_nxt;
  logic signed [50:0]   sum;
  logic signed [14:0]   n;
  logic [14:0]          nm;
  logic [DIV_BITS-1:0]  num;

  pq_ctl_t              ctl_r [0:DIV_BITS];
  logic [DIV_BITS-1:0]  quo_r [0:DIV_BITS];
  logic [15:0]          rem_r [0:DIV_BITS];
  logic                 neg_r [0:DIV_BITS];

  assign a_nxt = $signed({1'b0, steps_i}) * diff_i;
  assign sum   = a_r + (51'sd1 <<< 35);
  assign n     = sum[50:36];
  assign nm    = n[14] ? 15'(-n) : 15'(n);
  assign num   = {nm[13:0], 36'd0} + DIV_BITS'(steps_i >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r  <= '0;
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_a_r  <= ctl_i;
      ctl_r[0] <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= a_nxt;
      quo_r[0] <= num;
      rem_r[0] <= '0;
      neg_r[0] <= n[14];
    end
  end

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    logic [16:0] t;
    logic        ge;
    assign t  = {rem_r[j], quo_r[j][DIV_BITS-1]};
    assign ge = t >= {1'b0, steps_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j+1] <= '0;
      end else if (en) begin
        ctl_r[j+1] <= ctl_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= ge ? 16'(t - {1'b0, steps_i}) : t[15:0];
        quo_r[j+1] <= {quo_r[j][DIV_BITS-2:0], ge};
        neg_r[j+1] <= neg_r[j];
      end
    end
  end

  assign ctl_o = ctl_r[DIV_BITS];
  assign q_o   = quo_r[DIV_BITS];
  assign neg_o = neg_r[DIV_BITS];
endmodule
`default_nettype wire

@@ rtl/pq_exp.sv @@
// Exponent split, 28-stage 2^p product chain, base scaling and saturating shift.
// Depends on pq_pkg.
`default_nettype none
module pq_exp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  pq_pkg::pq_ctl_t             ctl_i,
  input  logic [pq_pkg::DIV_BITS-1:0] q_i,
  input  logic                        neg_i,
  input  logic [31:0]                 base_i,
  output logic                        valid_o,
  output logic [31:0]                 freq_o
);
  import pq_pkg::*;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x, r, b;
    x = x_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > x) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] exp2_coef(input int k);
    logic [63:0] c;
    c = 64'h1_0000_0000;
    for (int j = 1; j <= LOG_FRAC; j++) begin
      if (j <= k) c = isqrt64(c << 31);
    end
    return c[31:0];
  endfunction

  logic [21:0]          q_hi;
  logic [LOG_FRAC-1:0]  q_lo;
  logic [LOG_FRAC-1:0]  p_nxt;
  logic                 pnz;
  logic [22:0]          hi_adj;

  pq_ctl_t              ctl_r [0:LOG_FRAC];
  logic [LOG_FRAC-1:0]  p_r   [0:LOG_FRAC];
  logic [31:0]          m_r   [0:LOG_FRAC];
  logic [5:0]           sh_r  [0:LOG_FRAC];
  logic                 ovf_r [0:LOG_FRAC];
  logic                 uf_r  [0:LOG_FRAC];

  pq_ctl_t              ctl_m_r;
  logic [63:0]          prod_r;
  logic [5:0]           sh_m_r;
  logic                 ovf_m_r, uf_m_r;
  logic [63:0]          res;
  logic                 valid_r;
  logic [31:0]          freq_r;
  logic [31:0]          freq_nxt;

  assign q_hi   = q_i[DIV_BITS-1:LOG_FRAC];
  assign q_lo   = q_i[LOG_FRAC-1:0];
  assign pnz    = |q_lo;
  assign p_nxt  = neg_i ? LOG_FRAC'(-q_lo) : q_lo;
  assign hi_adj = 23'(q_hi) + 23'(pnz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= p_nxt;
      m_r[0] <= 32'h8000_0000;
      if (neg_i) begin
        ovf_r[0] <= 1'b0;
        uf_r[0]  <= hi_adj > 23'd32;
        sh_r[0]  <= 6'd31 + hi_adj[5:0];
      end else begin
        ovf_r[0] <= q_hi > 22'd31;
        uf_r[0]  <= 1'b0;
        sh_r[0]  <= 6'd31 - q_hi[5:0];
      end
    end
  end

  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_mul
    localparam logic [31:0] CK = exp2_coef(k + 1);
    logic [63:0] mp;
    assign mp = 64'(m_r[k]) * 64'(CK);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else if (en) begin
        ctl_r[k+1] <= ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[k+1]   <= p_r[k][LOG_FRAC-1-k] ? mp[62:31] : m_r[k];
        p_r[k+1]   <= p_r[k];
        sh_r[k+1]  <= sh_r[k];
        ovf_r[k+1] <= ovf_r[k];
        uf_r[k+1]  <= uf_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_m_r <= '0;
      valid_r <= 1'b0;
    end else if (en) begin
      ctl_m_r <= ctl_r[LOG_FRAC];
      valid_r <= ctl_m_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= 64'(base_i) * 64'(m_r[LOG_FRAC]);
      sh_m_r  <= sh_r[LOG_FRAC];
      ovf_m_r <= ovf_r[LOG_FRAC];
      uf_m_r  <= uf_r[LOG_FRAC];
      freq_r  <= freq_nxt;
    end
  end

  assign res = prod_r >> sh_m_r;

  always_comb begin
    if (ctl_m_r.zero || uf_m_r) begin
      freq_nxt = '0;
    end else if (ovf_m_r || (|res[63:32])) begin
      freq_nxt = '1;
    end else begin
      freq_nxt = res[31:0];
    end
  end

  assign valid_o = valid_r;
  assign freq_o  = freq_r;
endmodule
`default_nettype wire

@@ rtl/pitch_quantizer.sv @@
// Equal-tempered frequency quantizer: top level with configuration registers.
// One sample is accepted per cycle while the output is not stalled.
// The whole pipeline advances together and holds while the output is stalled.
// Synchronous reset clears all valid bits and loads 440 Hz and 12 steps per octave.
// Depends on pq_pkg, pq_log, pq_div and pq_exp.
`default_nettype none
module pitch_quantizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_frequency_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_frequency_out,
  input  logic                cfg_wr_en,
  input  pq_pkg::cfg_idx_t    cfg_index,
  input  logic [31:0]         cfg_data
);
  import pq_pkg::*;

  logic [31:0]         base_r;
  logic [15:0]         steps_r;
  logic                en;
  logic [31:0]         mag;
  pq_ctl_t             ctl_in, ctl_log, ctl_div;
  logic signed [33:0]  diff;
  logic [DIV_BITS-1:0] quo;
  logic                neg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BASE_RESET;
      steps_r <= STEPS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BASE:  base_r  <= cfg_data;
        CFG_STEPS: steps_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign mag          = in_frequency_in[31] ? (~in_frequency_in + 32'd1) : in_frequency_in;
  assign ctl_in.valid = in_valid;
  assign ctl_in.zero  = (mag == 32'd0) || (base_r == 32'd0) || (steps_r == 16'd0);

  pq_log u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (ctl_in),
    .mag_i  (mag),
    .base_i (base_r),
    .ctl_o  (ctl_log),
    .diff_o (diff)
  );

  pq_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_i   (ctl_log),
    .diff_i  (diff),
    .steps_i (steps_r),
    .ctl_o   (ctl_div),
    .q_o     (quo),
    .neg_o   (neg)
  );

  pq_exp u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_i   (ctl_div),
    .q_i     (quo),
    .neg_i   (neg),
    .base_i  (base_r),
    .valid_o (out_valid),
    .freq_o  (out_frequency_out)
  );
endmodule
`default_nettype wire

@@ rtl/pq_checker.sv @@
// Port-level checker for the pitch quantizer, bound to the top level.
// Depends on pitch_quantizer_defines.svh.
`default_nettype none
`include "pitch_quantizer_defines.svh"
module pq_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_stall,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [31:0]         out_frequency_out
);
  `PQ_ASSERT_RST(a_out_hold, out_valid && out_stall |=> out_valid, "output dropped under stall")
  `PQ_ASSERT_RST(a_stable, out_valid && out_stall |=> $stable(out_frequency_out), "output changed")
  `PQ_ASSERT_RST(a_stall, in_stall |-> out_valid && out_stall, "in_stall without out_stall")
  `PQ_ASSERT_ANY(a_reset_clear, $past(!rst_n) && rst_n |-> !out_valid, "valid after reset")
endmodule

bind pitch_quantizer pq_checker u_pq_checker (.*);
`default_nettype wire
